[design/ntrc_pkg.sv]
`timescale 1ns / 1ps
package ntrc_pkg;

  // fixed widths of the fields and the register port
  localparam int unsigned FieldW = 17;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned SectW  = 3;

  typedef logic [IdxW-1:0]  cfg_idx_t;
  typedef logic [SectW-1:0] sector_t;

  localparam cfg_idx_t RegSaturation    = 3'd0;
  localparam cfg_idx_t RegBrightness    = 3'd1;
  localparam cfg_idx_t RegGrayThreshold = 3'd2;
  localparam cfg_idx_t RegGrayscaleMode = 3'd3;
  localparam cfg_idx_t RegWoodGrainMode = 3'd4;

  // hue sectors, red through yellow up to magenta through red
  localparam sector_t SecRedYel = 3'd0;
  localparam sector_t SecYelGrn = 3'd1;
  localparam sector_t SecGrnCyn = 3'd2;
  localparam sector_t SecCynBlu = 3'd3;
  localparam sector_t SecBluMag = 3'd4;
  localparam sector_t SecMagRed = 3'd5;
  localparam int unsigned HueSectors = 6;

  typedef struct packed {
    logic gray;
    logic wood;
  } mode_t;

endpackage

[design/noise_to_rgb_colorizer_unit.sv]
`timescale 1ns / 1ps
// noise to rgb colorizer: one noise sample in, one rgb pixel out, one sample per clock.
// a sample is taken on a clock with start high and busy low; busy is high only in the
// first cycle after reset, so a new sample may follow in every cycle. the pixel shows on
// red_o/green_o/blue_o with out_valid_o high for exactly one cycle, once the sample is
// through the stages (clamp/wood fold, sector and gray byte, two multiplier stages,
// sector select and byte scaling); there is no output backpressure, so the pixel must be
// caught in that cycle. register writes take effect at once and belong in idle time only.
module noise_to_rgb_colorizer_unit import ntrc_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [FieldW-1:0] noise_value_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  cfg_idx_t          cfg_index_i,
  input  logic [FieldW-1:0] cfg_data_i,
  output logic              out_valid_o,
  output logic [ByteW-1:0]  red_o,
  output logic [ByteW-1:0]  green_o,
  output logic [ByteW-1:0]  blue_o
);

  localparam int unsigned F = FRACTION_BITS;
  localparam int unsigned Latency = 5;

  function automatic logic [ByteW-1:0] to_byte(input logic [F:0] x);
    logic [F+8:0] m;
    m = ((F+9)'(x) << 8) - (F+9)'(x);
    return m[F+7:F];
  endfunction

  logic busy_q;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy        = busy_q;
  assign cfg_ready_o = ~busy_q;
  assign accept      = start & ~busy_q;

  logic [F:0] sat, bri, thr;
  mode_t      mode;

  ntrc_cfg #(.FRACTION_BITS(FRACTION_BITS)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sat_o       (sat),
    .bri_o       (bri),
    .thr_o       (thr),
    .mode_o      (mode)
  );

  logic           prep_valid;
  sector_t        prep_sector;
  logic [F-1:0]   prep_frac;
  logic [ByteW-1:0] prep_gray;

  ntrc_prep #(.FRACTION_BITS(FRACTION_BITS)) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .noise_i  (noise_value_i),
    .mode_i   (mode),
    .thr_i    (thr),
    .valid_o  (prep_valid),
    .sector_o (prep_sector),
    .frac_o   (prep_frac),
    .gray_o   (prep_gray)
  );

  logic           hsv_valid;
  sector_t        hsv_sector;
  logic [F:0]     hsv_p, hsv_q, hsv_t;
  logic [ByteW-1:0] hsv_gray;

  ntrc_hsv #(.FRACTION_BITS(FRACTION_BITS)) u_hsv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (prep_valid),
    .sector_i (prep_sector),
    .frac_i   (prep_frac),
    .gray_i   (prep_gray),
    .sat_i    (sat),
    .bri_i    (bri),
    .valid_o  (hsv_valid),
    .sector_o (hsv_sector),
    .p_o      (hsv_p),
    .q_o      (hsv_q),
    .t_o      (hsv_t),
    .gray_o   (hsv_gray)
  );

  // stage 5: pick p/q/t/v per sector and scale to bytes, or pass the gray byte in grayscale mode
  logic [F:0]       rx, gx, bx;
  logic [ByteW-1:0] red_d, green_d, blue_d;
  logic [ByteW-1:0] red_q, green_q, blue_q;
  logic             valid5_q;

  always_comb begin
    case (hsv_sector)
      SecRedYel: begin rx = bri;   gx = hsv_t; bx = hsv_p; end
      SecYelGrn: begin rx = hsv_q; gx = bri;   bx = hsv_p; end
      SecGrnCyn: begin rx = hsv_p; gx = bri;   bx = hsv_t; end
      SecCynBlu: begin rx = hsv_p; gx = hsv_q; bx = bri;   end
      SecBluMag: begin rx = hsv_t; gx = hsv_p; bx = bri;   end
      default:   begin rx = bri;   gx = hsv_p; bx = hsv_q; end
    endcase
  end

  assign red_d   = mode.gray ? hsv_gray : to_byte(rx);
  assign green_d = mode.gray ? hsv_gray : to_byte(gx);
  assign blue_d  = mode.gray ? hsv_gray : to_byte(bx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid5_q <= 1'b0;
    end else begin
      valid5_q <= hsv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  assign out_valid_o = valid5_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

  logic [ByteW-1:0] v_byte;
  assign v_byte = to_byte(bri);

  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency out_valid_o)
    else $error("accepted transaction produced no result");

  a_result_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(accept, Latency))
    else $error("result without a matching transaction");

  a_gray_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mode.gray) |-> (red_o == green_o && green_o == blue_o))
    else $error("grayscale channels differ");

  a_hsv_has_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !mode.gray) |-> (red_o == v_byte || green_o == v_byte ||
                                     blue_o == v_byte))
    else $error("no channel carries the brightness level");

endmodule

[design/ntrc_cfg.sv]
`timescale 1ns / 1ps
module ntrc_cfg import ntrc_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  cfg_idx_t                 cfg_index_i,
  input  logic [FieldW-1:0]        cfg_data_i,
  output logic [FRACTION_BITS:0]   sat_o,
  output logic [FRACTION_BITS:0]   bri_o,
  output logic [FRACTION_BITS:0]   thr_o,
  output mode_t                    mode_o
);

  localparam int unsigned VW = (FRACTION_BITS + 1 > FieldW) ? FRACTION_BITS + 1 : FieldW;
  localparam logic [VW-1:0] OneV     = VW'(1) << FRACTION_BITS;
  localparam logic [VW-1:0] HalfV    = OneV >> 1;
  localparam logic [VW-1:0] FieldMax = VW'({FieldW{1'b1}});
  localparam logic [FieldW-1:0] OneRst  = (OneV > FieldMax) ? '1 : OneV[FieldW-1:0];
  localparam logic [FieldW-1:0] HalfRst = (HalfV > FieldMax) ? '1 : HalfV[FieldW-1:0];

  logic [FieldW-1:0] sat_q, bri_q, thr_q;
  mode_t             mode_q;

  function automatic logic [FRACTION_BITS:0] clamp_one(input logic [FieldW-1:0] x);
    logic [VW-1:0] xe;
    xe = VW'(x);
    return (xe > OneV) ? OneV[FRACTION_BITS:0] : xe[FRACTION_BITS:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q  <= OneRst;
      bri_q  <= OneRst;
      thr_q  <= HalfRst;
      mode_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegSaturation:    sat_q       <= cfg_data_i;
        RegBrightness:    bri_q       <= cfg_data_i;
        RegGrayThreshold: thr_q       <= cfg_data_i;
        RegGrayscaleMode: mode_q.gray <= cfg_data_i[0];
        RegWoodGrainMode: mode_q.wood <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign sat_o  = clamp_one(sat_q);
  assign bri_o  = clamp_one(bri_q);
  assign thr_o  = clamp_one(thr_q);
  assign mode_o = mode_q;

endmodule

[design/ntrc_prep.sv]
`timescale 1ns / 1ps
module ntrc_prep import ntrc_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [FieldW-1:0]          noise_i,
  input  mode_t                      mode_i,
  input  logic [FRACTION_BITS:0]     thr_i,
  output logic                       valid_o,
  output sector_t                    sector_o,
  output logic [FRACTION_BITS-1:0]   frac_o,
  output logic [ByteW-1:0]           gray_o
);

  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned VW = (F + 1 > FieldW) ? F + 1 : FieldW;
  localparam logic [VW-1:0] OneV = VW'(1) << F;

  function automatic logic [F:0] clamp_one(input logic [FieldW-1:0] x);
    logic [VW-1:0] xe;
    xe = VW'(x);
    return (xe > OneV) ? OneV[F:0] : xe[F:0];
  endfunction

  // stage 1: clamp and optional wood-grain fold
  logic [F:0]   h_clamp;
  logic [F+4:0] h_x10;
  logic [F:0]   h1_d, h1_q;
  logic         valid1_q;

  assign h_clamp = clamp_one(noise_i);
  assign h_x10   = ((F+5)'(h_clamp) << 3) + ((F+5)'(h_clamp) << 1);
  assign h1_d    = mode_i.wood ? {1'b0, h_x10[F-1:0]} : h_clamp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    h1_q <= h1_d;
  end

  // stage 2: hue sector, fraction and the grayscale byte
  logic [F+3:0]   h6;
  logic [3:0]     seg;
  logic [F+8:0]   h255;
  sector_t        sector_d, sector_q;
  logic [F-1:0]   frac_q;
  logic [ByteW-1:0] gray_d, gray_q;
  logic           valid2_q;

  assign h6       = ((F+4)'(h1_q) << 2) + ((F+4)'(h1_q) << 1);
  assign seg      = h6[F+3:F];
  // a hue of exactly one lands on sector six and wraps to zero
  assign sector_d = (seg >= 4'(HueSectors)) ? SecRedYel : seg[SectW-1:0];
  assign h255     = ((F+9)'(h1_q) << 8) - (F+9)'(h1_q);
  assign gray_d   = (h1_q < thr_i) ? '0 : h255[F+7:F];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
    end else begin
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sector_q <= sector_d;
    frac_q   <= h6[F-1:0];
    gray_q   <= gray_d;
  end

  assign valid_o  = valid2_q;
  assign sector_o = sector_q;
  assign frac_o   = frac_q;
  assign gray_o   = gray_q;

endmodule

[design/ntrc_hsv.sv]
`timescale 1ns / 1ps
module ntrc_hsv import ntrc_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  sector_t                    sector_i,
  input  logic [FRACTION_BITS-1:0]   frac_i,
  input  logic [ByteW-1:0]           gray_i,
  input  logic [FRACTION_BITS:0]     sat_i,
  input  logic [FRACTION_BITS:0]     bri_i,
  output logic                       valid_o,
  output sector_t                    sector_o,
  output logic [FRACTION_BITS:0]     p_o,
  output logic [FRACTION_BITS:0]     q_o,
  output logic [FRACTION_BITS:0]     t_o,
  output logic [ByteW-1:0]           gray_o
);

  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned PW = 2 * F + 2;
  localparam logic [F:0] One = {1'b1, {F{1'b0}}};

  // stage 3: f*s, (1-f)*s and p
  logic [F:0]    ofrac, osat;
  logic [PW-1:0] prod_a, prod_b, prod_p;
  logic [F:0]    a_q, b_q, p3_q;
  sector_t       sector3_q;
  logic [ByteW-1:0] gray3_q;
  logic          valid3_q;

  assign ofrac  = One - {1'b0, frac_i};
  assign osat   = One - sat_i;
  assign prod_a = PW'(frac_i) * PW'(sat_i);
  assign prod_b = PW'(ofrac) * PW'(sat_i);
  assign prod_p = PW'(bri_i) * PW'(osat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
    end else begin
      valid3_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= prod_a[2*F:F];
    b_q       <= prod_b[2*F:F];
    p3_q      <= prod_p[2*F:F];
    sector3_q <= sector_i;
    gray3_q   <= gray_i;
  end

  // stage 4: q = v*(1 - f*s), t = v*(1 - (1-f)*s)
  logic [PW-1:0] prod_q, prod_t;
  logic [F:0]    q_q, t_q, p4_q;
  sector_t       sector4_q;
  logic [ByteW-1:0] gray4_q;
  logic          valid4_q;

  assign prod_q = PW'(bri_i) * PW'(One - a_q);
  assign prod_t = PW'(bri_i) * PW'(One - b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid4_q <= 1'b0;
    end else begin
      valid4_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q       <= prod_q[2*F:F];
    t_q       <= prod_t[2*F:F];
    p4_q      <= p3_q;
    sector4_q <= sector3_q;
    gray4_q   <= gray3_q;
  end

  assign valid_o  = valid4_q;
  assign sector_o = sector4_q;
  assign p_o      = p4_q;
  assign q_o      = q_q;
  assign t_o      = t_q;
  assign gray_o   = gray4_q;

endmodule
